[rtl/mkurng_pkg.sv]
// Shared constants, types and helper functions for the multi-kind uniform generator.
`timescale 1ns / 1ps
`default_nettype none

package mkurng_pkg;

  localparam int WORD_W  = 32;
  localparam int KIND_W  = 2;
  localparam int IDX_W   = 2;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = WORD_W + MUL_B_W;

  localparam logic [KIND_W-1:0] KIND_WH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MWC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SD  = 2'd2;

  localparam logic ACTION_DRAW   = 1'b0;
  localparam logic ACTION_RESEED = 1'b1;

  localparam logic [WORD_W-1:0]  SEED_RESET      = 32'd123;
  localparam logic [WORD_W-1:0]  LOW16           = 32'h0000_ffff;
  localparam logic [MUL_B_W-1:0] LCG_MULT        = 17'd69069;
  localparam logic [MUL_B_W-1:0] MWC_MULT_FIRST  = 17'd36969;
  localparam logic [MUL_B_W-1:0] MWC_MULT_SECOND = 17'd18000;

  // Remainder / divide unit: a 40-bit product followed by 32 zero bits,
  // consumed RADIX_BITS (4) bits per divider step.
  localparam int MOD_W      = 15;
  localparam int WH_PROD_W  = 40;
  localparam int RADIX_BITS = 4;
  localparam int DIV_W      = WH_PROD_W + WORD_W;
  localparam int DIV_STEPS  = DIV_W / RADIX_BITS;
  localparam int REM_STEP   = WH_PROD_W / RADIX_BITS - 1;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [MOD_W-1:0]  mod_t;

  typedef struct packed {
    mod_t                  rem;
    logic [RADIX_BITS-1:0] quo;
  } div_digit_t;

  function automatic mod_t wh_modulus(input logic [IDX_W-1:0] idx);
    case (idx)
      2'd0:    return 15'd30269;
      2'd1:    return 15'd30307;
      default: return 15'd30323;
    endcase
  endfunction

  function automatic logic [MUL_B_W-1:0] wh_multiplier(input logic [IDX_W-1:0] idx);
    case (idx)
      2'd0:    return 17'd171;
      2'd1:    return 17'd172;
      default: return 17'd170;
    endcase
  endfunction

  function automatic word_t nonzero(input word_t w);
    return (w == '0) ? word_t'(1) : w;
  endfunction

  function automatic word_t shift_xor(input word_t w);
    word_t t;
    t = w ^ (w >> 15);
    return t ^ (t << 17);
  endfunction

  // One radix-2^RADIX_BITS restoring step: shift in the bits, subtract where it fits.
  function automatic div_digit_t div_digit(input mod_t rem, input logic [RADIX_BITS-1:0] bits,
                                           input mod_t modulus);
    logic [MOD_W:0]        t;
    mod_t                  r;
    logic [RADIX_BITS-1:0] q;
    div_digit_t            res;
    r = rem;
    q = '0;
    for (int i = 0; i < RADIX_BITS; i++) begin
      t = {r, bits[RADIX_BITS-1-i]};
      if (t >= {1'b0, modulus}) begin
        t = t - {1'b0, modulus};
        q[RADIX_BITS-1-i] = 1'b1;
      end
      r = t[MOD_W-1:0];
    end
    res.rem = r;
    res.quo = q;
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/multi_kind_uniform_rng.sv]
// Multi-kind uniform random generator: sequencer, shared multiplier and remainder unit.
`timescale 1ns / 1ps
`default_nettype none

// Uniform random generator with three kinds chosen by generator_kind (0 Wichmann-Hill,
// 1 multiply-with-carry, 2 Super-Duper; code 3 gives a zero fraction on draw and ignores
// reseed). A beat with action draw returns one Q0.32 fraction beat; a beat with action
// reseed expands seed_value into the seed words and returns nothing. One beat is worked
// at a time and in_stall stays high until it is done. Work from accept to the result
// sitting in the output register:
//   Wichmann-Hill draw   : 3 words x (multiply + load + 18 divider steps)
//   Wichmann-Hill reseed : 2 x (multiply + write-back), then 3 x (load + 10 divider steps)
//   other kinds : one multiply + write-back, two for a multiply-with-carry draw.
// The Wichmann-Hill work is done by the remainder/divide unit, which retires four
// dividend bits per cycle: the first 40 bits leave word*a mod m (word mod m on a
// reseed), the 32 zero bits after them give the term floor(word * 2^32 / m). The
// other kinds rest on the one 32x17 multiplier, which is registered before use. The
// output register frees the core: a result waits there under out_stall while the
// next beat is accepted. Write generator_kind only while the block is idle.
module multi_kind_uniform_rng (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write_en,
  input  wire logic [mkurng_pkg::KIND_W-1:0]    cfg_write_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             action,
  input  wire logic [mkurng_pkg::WORD_W-1:0]    seed_value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [mkurng_pkg::WORD_W-1:0]         fraction
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a beat
  localparam logic [2:0] ST_MUL  = 3'd1;  // run the shared multiplier
  localparam logic [2:0] ST_WB   = 3'd2;  // write back a multiplier result
  localparam logic [2:0] ST_LOAD = 3'd3;  // load the divider
  localparam logic [2:0] ST_DIV  = 3'd4;  // divider steps
  localparam logic [2:0] ST_OUT  = 3'd5;  // hand the result to the output register

  logic [2:0]                          state;
  logic [mkurng_pkg::KIND_W-1:0]       generator_kind;
  logic                                reseed_op;
  logic [mkurng_pkg::IDX_W-1:0]        idx;
  logic [mkurng_pkg::STEP_W-1:0]       step;
  logic [mkurng_pkg::PROD_W-1:0]       prod;
  logic [mkurng_pkg::DIV_W-1:0]        div_sh;
  mkurng_pkg::mod_t                    rem;
  mkurng_pkg::word_t                   quo;
  mkurng_pkg::word_t                   acc;
  mkurng_pkg::word_t                   seed_first;
  mkurng_pkg::word_t                   seed_second;
  mkurng_pkg::word_t                   seed_third;

  mkurng_pkg::word_t                   word_sel;
  mkurng_pkg::word_t                   mul_a;
  logic [mkurng_pkg::MUL_B_W-1:0]      mul_b;
  logic [mkurng_pkg::PROD_W-1:0]       mul_prod;
  mkurng_pkg::mod_t                    modulus;
  mkurng_pkg::div_digit_t              digit;
  mkurng_pkg::word_t                   quo_next;
  mkurng_pkg::word_t                   rem_word;
  mkurng_pkg::word_t                   lcg_word;
  mkurng_pkg::word_t                   mwc_word;
  mkurng_pkg::word_t                   sd_word;
  logic                                div_last;
  logic                                in_fire;
  logic                                out_free;

  assign in_stall = (state != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    case (idx)
      2'd0:    word_sel = seed_first;
      2'd1:    word_sel = seed_second;
      default: word_sel = seed_third;
    endcase
  end

  // Operand select for the shared multiplier
  always_comb begin
    if (reseed_op) begin
      mul_a = (idx == 2'd2) ? seed_second : seed_first;
      mul_b = mkurng_pkg::LCG_MULT;
    end else begin
      case (generator_kind)
        mkurng_pkg::KIND_WH: begin
          mul_a = word_sel;
          mul_b = mkurng_pkg::wh_multiplier(idx);
        end
        mkurng_pkg::KIND_MWC: begin
          mul_a = word_sel & mkurng_pkg::LOW16;
          mul_b = (idx == 2'd0) ? mkurng_pkg::MWC_MULT_FIRST : mkurng_pkg::MWC_MULT_SECOND;
        end
        default: begin
          mul_a = seed_second;
          mul_b = mkurng_pkg::LCG_MULT;
        end
      endcase
    end
  end

  assign mul_prod = mkurng_pkg::PROD_W'(mul_a) * mkurng_pkg::PROD_W'(mul_b);

  assign modulus  = mkurng_pkg::wh_modulus(idx);
  assign digit    = mkurng_pkg::div_digit(rem, div_sh[mkurng_pkg::DIV_W-1 -: mkurng_pkg::RADIX_BITS],
                                          modulus);
  assign quo_next = {quo[mkurng_pkg::WORD_W-mkurng_pkg::RADIX_BITS-1:0], digit.quo};
  assign rem_word = mkurng_pkg::WORD_W'(digit.rem);
  assign lcg_word = prod[mkurng_pkg::WORD_W-1:0];
  assign mwc_word = prod[mkurng_pkg::WORD_W-1:0] + (word_sel >> 16);
  assign sd_word  = mkurng_pkg::shift_xor(seed_first);
  assign div_last = reseed_op ? (step == mkurng_pkg::STEP_W'(mkurng_pkg::REM_STEP))
                              : (step == mkurng_pkg::STEP_W'(mkurng_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      generator_kind <= mkurng_pkg::KIND_WH;
      reseed_op      <= 1'b0;
      idx            <= '0;
      step           <= '0;
      out_valid      <= 1'b0;
      seed_first     <= mkurng_pkg::SEED_RESET;
      seed_second    <= '0;
      seed_third     <= '0;
    end else begin
      if (cfg_write_en) begin
        generator_kind <= cfg_write_data;
      end
      // Drop the output beat once taken; a new load below overrides this
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            reseed_op <= action;
            acc       <= '0;
            if (action == mkurng_pkg::ACTION_RESEED) begin
              if (generator_kind == mkurng_pkg::KIND_WH || generator_kind == mkurng_pkg::KIND_MWC
                  || generator_kind == mkurng_pkg::KIND_SD) begin
                seed_first <= seed_value;
                idx        <= 2'd1;
                state      <= ST_MUL;
              end
            end else begin
              case (generator_kind)
                mkurng_pkg::KIND_WH: begin
                  idx   <= 2'd0;
                  state <= ST_MUL;
                end
                mkurng_pkg::KIND_MWC: begin
                  idx   <= 2'd0;
                  state <= ST_MUL;
                end
                mkurng_pkg::KIND_SD: begin
                  idx   <= 2'd1;
                  state <= ST_MUL;
                end
                default: begin
                  state <= ST_OUT;
                end
              endcase
            end
          end
        end

        ST_MUL: begin
          prod  <= mul_prod;
          state <= (!reseed_op && generator_kind == mkurng_pkg::KIND_WH) ? ST_LOAD : ST_WB;
        end

        ST_LOAD: begin
          if (reseed_op) begin
            div_sh <= {{(mkurng_pkg::DIV_W - 2*mkurng_pkg::WORD_W){1'b0}}, word_sel,
                       {mkurng_pkg::WORD_W{1'b0}}};
          end else begin
            div_sh <= {prod[mkurng_pkg::WH_PROD_W-1:0], {mkurng_pkg::WORD_W{1'b0}}};
          end
          rem   <= '0;
          quo   <= '0;
          step  <= '0;
          state <= ST_DIV;
        end

        ST_DIV: begin
          div_sh <= div_sh << mkurng_pkg::RADIX_BITS;
          rem    <= digit.rem;
          quo    <= quo_next;
          step   <= step + mkurng_pkg::STEP_W'(1);
          // First 40 bits consumed: the remainder is the new word
          if (step == mkurng_pkg::STEP_W'(mkurng_pkg::REM_STEP)) begin
            case (idx)
              2'd0:    seed_first  <= reseed_op ? mkurng_pkg::nonzero(rem_word) : rem_word;
              2'd1:    seed_second <= reseed_op ? mkurng_pkg::nonzero(rem_word) : rem_word;
              default: seed_third  <= reseed_op ? mkurng_pkg::nonzero(rem_word) : rem_word;
            endcase
          end
          if (div_last) begin
            if (reseed_op) begin
              if (idx == 2'd2) begin
                state <= ST_IDLE;
              end else begin
                idx   <= idx + mkurng_pkg::IDX_W'(1);
                state <= ST_LOAD;
              end
            end else begin
              // Sum of the terms wraps mod 1
              acc <= acc + quo_next;
              if (idx == 2'd2) begin
                state <= ST_OUT;
              end else begin
                idx   <= idx + mkurng_pkg::IDX_W'(1);
                state <= ST_MUL;
              end
            end
          end
        end

        ST_WB: begin
          if (reseed_op) begin
            case (generator_kind)
              mkurng_pkg::KIND_WH: begin
                if (idx == 2'd1) begin
                  seed_second <= lcg_word;
                  idx         <= 2'd2;
                  state       <= ST_MUL;
                end else begin
                  seed_third <= lcg_word;
                  idx        <= 2'd0;
                  state      <= ST_LOAD;
                end
              end
              mkurng_pkg::KIND_MWC: begin
                seed_first  <= mkurng_pkg::nonzero(seed_first);
                seed_second <= mkurng_pkg::nonzero(lcg_word);
                state       <= ST_IDLE;
              end
              default: begin
                seed_first  <= mkurng_pkg::nonzero(seed_first);
                seed_second <= lcg_word | mkurng_pkg::word_t'(1);
                state       <= ST_IDLE;
              end
            endcase
          end else if (generator_kind == mkurng_pkg::KIND_MWC) begin
            if (idx == 2'd0) begin
              seed_first <= mwc_word;
              idx        <= 2'd1;
              state      <= ST_MUL;
            end else begin
              seed_second <= mwc_word;
              acc         <= (seed_first << 16) ^ (mwc_word & mkurng_pkg::LOW16);
              state       <= ST_OUT;
            end
          end else begin
            seed_first  <= sd_word;
            seed_second <= lcg_word;
            acc         <= sd_word ^ lcg_word;
            state       <= ST_OUT;
          end
        end

        ST_OUT: begin
          // Hold until the output register is free
          if (out_free) begin
            fraction  <= acc;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Divider remainder always stays below the selected modulus
  assert property (@(posedge clk) disable iff (rst) (state == ST_DIV) |-> (rem < modulus))
    else $error("divider remainder not below modulus");

  // A new output beat only comes from the hand-off state
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(state) == ST_OUT)
    else $error("output beat loaded outside hand-off");

  // A reseed never produces a result
  assert property (@(posedge clk) disable iff (rst) (state == ST_OUT) |-> !reseed_op)
    else $error("reseed reached result hand-off");

  // After a Wichmann-Hill draw every word is reduced below its modulus
  assert property (@(posedge clk) disable iff (rst)
      (state == ST_OUT && generator_kind == mkurng_pkg::KIND_WH)
      |-> (seed_first < mkurng_pkg::word_t'(mkurng_pkg::wh_modulus(2'd0)))
       && (seed_second < mkurng_pkg::word_t'(mkurng_pkg::wh_modulus(2'd1)))
       && (seed_third < mkurng_pkg::word_t'(mkurng_pkg::wh_modulus(2'd2))))
    else $error("Wichmann-Hill word not reduced");

endmodule

`default_nettype wire
